>>> sv/pci_isa_bridge_config_space_defines.svh
// ----------------------------------------------------------------------------
// PCI-to-ISA bridge configuration space: assertion macros
// Shared forms for the concurrent checks on the bridge ports.
// ----------------------------------------------------------------------------
`ifndef PCI_ISA_BRIDGE_CONFIG_SPACE_DEFINES_SVH
`define PCI_ISA_BRIDGE_CONFIG_SPACE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PIB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PIB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/pib_pkg.sv
// ----------------------------------------------------------------------------
// PCI-to-ISA bridge configuration space package
// Access codes, offsets and the reset image of the configuration bytes.
// ----------------------------------------------------------------------------
package pib_pkg;

	typedef enum logic {
		REQ_READ  = 1'b0,
		REQ_WRITE = 1'b1
	} req_type_t;

	localparam logic [7:0] OFF_COMMAND    = 8'h04;
	localparam logic [7:0] OFF_STATUS_LO  = 8'h05;
	localparam logic [7:0] OFF_STATUS_HI  = 8'h06;
	localparam logic [7:0] OFF_STATUS_FIX = 8'h07;
	localparam logic [7:0] OFF_ROUTE_LO   = 8'h60;
	localparam logic [7:0] OFF_ROUTE_HI   = 8'h63;

	localparam logic [7:0] CMD_KEEP_MASK  = 8'h08;
	localparam logic [7:0] CMD_FORCE_ONES = 8'h07;
	localparam logic [7:0] STATUS_FIXED   = 8'h02;
	localparam logic [7:0] ABSENT_FN_BYTE = 8'hff;

	// Contents of the configuration bytes right after reset.
	function automatic logic [7:0] reset_byte(input logic [7:0] off);
		logic [7:0] b;
		case (off)
			8'h00:   b = 8'h86;
			8'h01:   b = 8'h80;
			8'h02:   b = 8'h84;
			8'h03:   b = 8'h04;
			8'h04:   b = 8'h07;
			8'h07:   b = 8'h02;
			8'h08:   b = 8'h03;
			8'h40:   b = 8'h20;
			8'h42:   b = 8'h04;
			8'h44:   b = 8'h20;
			8'h45:   b = 8'h10;
			8'h46:   b = 8'h0f;
			8'h48:   b = 8'h01;
			8'h49:   b = 8'h10;
			8'h4a:   b = 8'h10;
			8'h4b:   b = 8'h0f;
			8'h4c:   b = 8'h56;
			8'h4d:   b = 8'h40;
			8'h4e:   b = 8'h07;
			8'h4f:   b = 8'h4f;
			8'h60:   b = 8'h80;
			8'h61:   b = 8'h80;
			8'h62:   b = 8'h80;
			8'h63:   b = 8'h80;
			8'h80:   b = 8'h78;
			8'ha0:   b = 8'h08;
			8'ha8:   b = 8'h0f;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

>>> sv/pib_if.sv
// ----------------------------------------------------------------------------
// PCI-to-ISA bridge configuration space channels
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface pib_req_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [2:0] function_number;
	logic [7:0] reg_offset;
	logic [7:0] write_byte;

	modport source (output valid, req_type, function_number, reg_offset, write_byte,
		input ready);
	modport sink (input valid, req_type, function_number, reg_offset, write_byte,
		output ready);
endinterface

interface pib_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_byte;
	logic       route_update;
	logic [1:0] route_pin;
	logic       route_disabled;
	logic [3:0] route_irq;

	modport source (output valid, read_byte, route_update, route_pin, route_disabled,
		route_irq, input ready);
	modport sink (input valid, read_byte, route_update, route_pin, route_disabled,
		route_irq, output ready);
endinterface

>>> sv/pci_isa_bridge_config_space.sv
// ----------------------------------------------------------------------------
// PCI-to-ISA bridge configuration space
// 256-byte configuration register file with interrupt routing reports.
// ----------------------------------------------------------------------------
// Each request word is one configuration byte access and gives exactly one
// response word. The block takes one word per cycle unless the response
// channel stalls it. An accepted word first reads the byte store (whose read
// data is registered), then the result is formed in the output register.
// A write lands in the store at the edge it is accepted, so a read accepted
// right after it sees the new value. Each byte has a valid bit cleared by
// reset, and a byte never written reads its reset default, so no clearing
// pass is needed and the block is ready immediately after reset.
module pci_isa_bridge_config_space (
	input  logic    clk,
	input  logic    arst_n,
	pib_req_if.sink req,
	pib_rsp_if.source rsp
);

	logic [7:0] mem_q [256];
	logic [255:0] vld_q;

	logic       in_acc;
	logic       adv_s2;
	logic       wr_en;
	logic [7:0] wr_val;
	logic       is_route;

	logic       v_s1;
	logic       wr_s1;
	logic       fn_absent_s1;
	logic [7:0] off_s1;
	logic [7:0] mem_s1;
	logic       vld_s1;
	logic       upd_s1;
	logic [1:0] pin_s1;
	logic       dis_s1;
	logic [3:0] irq_s1;

	logic       v_s2;
	logic [7:0] rb_s2;
	logic       upd_s2;
	logic [1:0] pin_s2;
	logic       dis_s2;
	logic [3:0] irq_s2;

	assign adv_s2    = !v_s2 || rsp.ready;
	assign req.ready = !v_s1 || adv_s2;
	assign in_acc    = req.valid && req.ready;

	always_comb begin
		wr_en    = 1'b0;
		wr_val   = req.write_byte;
		is_route = 1'b0;
		if (req.req_type == pib_pkg::REQ_WRITE && req.function_number == 3'd0) begin
			wr_en = !(req.reg_offset inside {[8'h00:8'h03], [8'h08:8'h0b], [8'h0e:8'h4b]});
			is_route = req.reg_offset inside {[pib_pkg::OFF_ROUTE_LO:pib_pkg::OFF_ROUTE_HI]};
		end
		case (req.reg_offset)
			pib_pkg::OFF_COMMAND: begin
				wr_val = (req.write_byte & pib_pkg::CMD_KEEP_MASK) | pib_pkg::CMD_FORCE_ONES;
			end
			pib_pkg::OFF_STATUS_LO, pib_pkg::OFF_STATUS_HI: begin
				wr_val = 8'h00;
			end
			pib_pkg::OFF_STATUS_FIX: begin
				wr_val = pib_pkg::STATUS_FIXED;
			end
			default: begin
				wr_val = req.write_byte;
			end
		endcase
	end

	// Byte store: registered read, write on the same accepting edge.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			mem_s1 <= mem_q[req.reg_offset];
			if (wr_en) begin
				mem_q[req.reg_offset] <= wr_val;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (in_acc && wr_en) begin
			vld_q[req.reg_offset] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (in_acc) begin
				v_s1 <= 1'b1;
			end else if (adv_s2) begin
				v_s1 <= 1'b0;
			end
			if (adv_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			wr_s1        <= req.req_type == pib_pkg::REQ_WRITE;
			fn_absent_s1 <= req.function_number != 3'd0;
			off_s1       <= req.reg_offset;
			vld_s1       <= vld_q[req.reg_offset];
			upd_s1       <= is_route;
			// Route bytes cover pins A, C, B, D in offset order.
			pin_s1       <= is_route ? {req.reg_offset[0], req.reg_offset[1]} : 2'd0;
			dis_s1       <= is_route && req.write_byte[7];
			irq_s1       <= (is_route && !req.write_byte[7]) ? req.write_byte[3:0] : 4'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			if (wr_s1) begin
				rb_s2 <= 8'h00;
			end else if (fn_absent_s1) begin
				rb_s2 <= pib_pkg::ABSENT_FN_BYTE;
			end else begin
				rb_s2 <= vld_s1 ? mem_s1 : pib_pkg::reset_byte(off_s1);
			end
			upd_s2 <= upd_s1;
			pin_s2 <= pin_s1;
			dis_s2 <= dis_s1;
			irq_s2 <= irq_s1;
		end
	end

	assign rsp.valid          = v_s2;
	assign rsp.read_byte      = rb_s2;
	assign rsp.route_update   = upd_s2;
	assign rsp.route_pin      = pin_s2;
	assign rsp.route_disabled = dis_s2;
	assign rsp.route_irq      = irq_s2;

endmodule

>>> sv/pib_checker.sv
// ----------------------------------------------------------------------------
// PCI-to-ISA bridge configuration space checker
// Port-level checks on the response channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "pci_isa_bridge_config_space_defines.svh"

module pib_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [7:0] read_byte,
	input logic       route_update,
	input logic [1:0] route_pin,
	input logic       route_disabled,
	input logic [3:0] route_irq
);

	// Routing fields are meaningful only on an update.
	`PIB_ASSERT_NOW(a_route_quiet, rsp_valid && !route_update, route_pin == 2'd0 && !route_disabled && route_irq == 4'd0, "routing fields set without an update")

	`PIB_ASSERT_NOW(a_disabled_irq, rsp_valid && route_disabled, route_irq == 4'd0 && route_update, "disabled route carries an IRQ")

	// An update comes only from a write, which reads back zero.
	`PIB_ASSERT_NOW(a_update_write, rsp_valid && route_update, read_byte == 8'h00, "routing update with nonzero read data")

	`PIB_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(read_byte) && $stable(route_update) && $stable(route_pin) && $stable(route_disabled) && $stable(route_irq), "stalled response changed")

endmodule

bind pci_isa_bridge_config_space pib_checker u_pib_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.read_byte      (rsp.read_byte),
	.route_update   (rsp.route_update),
	.route_pin      (rsp.route_pin),
	.route_disabled (rsp.route_disabled),
	.route_irq      (rsp.route_irq)
);

>>> test/pib_cfg_checker.sv
// ----------------------------------------------------------------------------
// PCI-to-ISA bridge configuration space: response checker
// Watches the request and response channels and keeps a shadow copy of the
// 256 configuration bytes. Every accepted request word produces one expected
// response word, and every accepted response word is compared, field by
// field, against the oldest expectation.
// ----------------------------------------------------------------------------
module pib_cfg_checker
	import pib_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	pib_req_if   req,
	pib_rsp_if   rsp,
	output int   fail_count,
	output int   pending,
	output int   replies_seen,
	output int   routes_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] FN_PRESENT   = 3'd0;
	localparam logic [7:0] RO_ID_HI     = 8'h03;
	localparam logic [7:0] RO_CLASS_LO  = 8'h08;
	localparam logic [7:0] RO_CLASS_HI  = 8'h0b;
	localparam logic [7:0] RO_HDR_LO    = 8'h0e;
	localparam logic [7:0] RO_HDR_HI    = 8'h4b;
	localparam int         ROUTE_OFF_BIT = 7;
	localparam logic [1:0] PIN_A = 2'd0;
	localparam logic [1:0] PIN_B = 2'd1;
	localparam logic [1:0] PIN_C = 2'd2;
	localparam logic [1:0] PIN_D = 2'd3;
	localparam int         MAX_REPORTS = 10;

	typedef struct packed {
		logic [7:0] read_byte;
		logic       route_update;
		logic [1:0] route_pin;
		logic       route_disabled;
		logic [3:0] route_irq;
	} cfg_reply_t;

	logic [7:0] shadow_space [256];
	cfg_reply_t replies_due [$];
	int mismatches;
	int n_replies;
	int n_routes;

	function automatic logic [7:0] power_on_byte(input logic [7:0] off);
		case (off)
			8'h00: return 8'h86;
			8'h01: return 8'h80;
			8'h02: return 8'h84;
			8'h03: return 8'h04;
			8'h04: return 8'h07;
			8'h07: return 8'h02;
			8'h08: return 8'h03;
			8'h40, 8'h44: return 8'h20;
			8'h42: return 8'h04;
			8'h45, 8'h49, 8'h4a: return 8'h10;
			8'h46, 8'h4b, 8'ha8: return 8'h0f;
			8'h48: return 8'h01;
			8'h4c: return 8'h56;
			8'h4d: return 8'h40;
			8'h4e: return 8'h07;
			8'h4f: return 8'h4f;
			8'h60, 8'h61, 8'h62, 8'h63: return 8'h80;
			8'h80: return 8'h78;
			8'ha0: return 8'h08;
			default: return 8'h00;
		endcase
	endfunction

	function automatic logic is_read_only(input logic [7:0] off);
		return (off <= RO_ID_HI) || (off >= RO_CLASS_LO && off <= RO_CLASS_HI) ||
			(off >= RO_HDR_LO && off <= RO_HDR_HI);
	endfunction

	// The routing bytes are laid out A, C, B, D.
	function automatic logic [1:0] routed_pin(input logic [7:0] off);
		case (8'(off - OFF_ROUTE_LO))
			8'd0:    return PIN_A;
			8'd1:    return PIN_C;
			8'd2:    return PIN_B;
			default: return PIN_D;
		endcase
	endfunction

	task automatic apply_access(input logic kind, input logic [2:0] fn, input logic [7:0] off,
		input logic [7:0] data);
		cfg_reply_t r;
		logic [7:0] stored;
		r = '0;
		stored = data;
		if (kind == REQ_READ) begin
			r.read_byte = (fn != FN_PRESENT) ? ABSENT_FN_BYTE : shadow_space[off];
		end else if (fn == FN_PRESENT && !is_read_only(off)) begin
			if (off == OFF_COMMAND) begin
				stored = (data & CMD_KEEP_MASK) | CMD_FORCE_ONES;
			end else if (off == OFF_STATUS_LO || off == OFF_STATUS_HI) begin
				stored = 8'h00;
			end else if (off == OFF_STATUS_FIX) begin
				stored = STATUS_FIXED;
			end else if (off >= OFF_ROUTE_LO && off <= OFF_ROUTE_HI) begin
				r.route_update   = 1'b1;
				r.route_pin      = routed_pin(off);
				r.route_disabled = data[ROUTE_OFF_BIT];
				r.route_irq      = data[ROUTE_OFF_BIT] ? 4'h0 : data[3:0];
			end
			shadow_space[off] = stored;
		end
		replies_due.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		cfg_reply_t got;
		cfg_reply_t want;
		if (!arst_n) begin
			foreach (shadow_space[i]) shadow_space[i] = power_on_byte(8'(i));
			replies_due.delete();
			mismatches = 0;
			n_replies  = 0;
			n_routes   = 0;
		end else begin
			// Responses are checked before this edge's request is taken in; the
			// block never answers a word in the cycle it accepts it.
			if (rsp.valid && rsp.ready) begin
				got = {rsp.read_byte, rsp.route_update, rsp.route_pin, rsp.route_disabled,
					rsp.route_irq};
				n_replies++;
				if (got.route_update) n_routes++;
				if (replies_due.size() == 0) begin
					if (mismatches < MAX_REPORTS)
						$display("%0t unexpected response word: rd=%02h upd=%0d pin=%0d dis=%0d irq=%0d",
							$realtime, got.read_byte, got.route_update, got.route_pin,
							got.route_disabled, got.route_irq);
					mismatches++;
				end else begin
					want = replies_due.pop_front();
					if (got.read_byte !== want.read_byte ||
						got.route_update !== want.route_update ||
						got.route_pin !== want.route_pin ||
						got.route_disabled !== want.route_disabled ||
						got.route_irq !== want.route_irq) begin
						if (mismatches < MAX_REPORTS) begin
							$display("%0t response mismatch, response word %0d:", $realtime, n_replies);
							$display("  expected rd=%02h upd=%0d pin=%0d dis=%0d irq=%0d",
								want.read_byte, want.route_update, want.route_pin,
								want.route_disabled, want.route_irq);
							$display("  actual   rd=%02h upd=%0d pin=%0d dis=%0d irq=%0d",
								got.read_byte, got.route_update, got.route_pin,
								got.route_disabled, got.route_irq);
						end
						mismatches++;
					end
				end
			end
			if (req.valid && req.ready)
				apply_access(req.req_type, req.function_number, req.reg_offset, req.write_byte);
		end
		fail_count   <= mismatches;
		pending      <= replies_due.size();
		replies_seen <= n_replies;
		routes_seen  <= n_routes;
	end

endmodule

>>> test/tb_pci_isa_bridge_config_space.sv
// ----------------------------------------------------------------------------
// PCI-to-ISA bridge configuration space testbench
// Drives configuration reads and writes in random bursts, stalls the response
// side on changing patterns with one long hold-off, and lets the checker
// compare every response word. Reports the verdict at the end of the run.
// ----------------------------------------------------------------------------
module tb_pci_isa_bridge_config_space;
	timeunit 1ns;
	timeprecision 1ps;

	import pib_pkg::*;

	localparam int         RESET_CYCLES = 6;
	localparam int         RANDOM_WORDS = 1350;
	localparam int         HOLD_AT      = 400;
	localparam int         HOLD_CYCLES  = 120;
	localparam int         DRAIN_CYCLES = 12;
	localparam int         CYCLE_LIMIT  = 200000;
	localparam logic [2:0] FN_MAIN      = 3'd0;
	localparam logic [2:0] FN_LAST      = 3'd7;

	typedef enum int {
		RX_ALWAYS,
		RX_COIN,
		RX_ONE_IN_FOUR,
		RX_MOSTLY
	} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n;
	int   words_sent = 0;
	int   cycles = 0;
	int   fail_count;
	int   pending;
	int   replies_seen;
	int   routes_seen;

	pib_req_if req_ch();
	pib_rsp_if rsp_ch();

	pci_isa_bridge_config_space dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	pib_cfg_checker cfg_model (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req_ch),
		.rsp          (rsp_ch),
		.fail_count   (fail_count),
		.pending      (pending),
		.replies_seen (replies_seen),
		.routes_seen  (routes_seen)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words still expected", cycles, pending);
			$display("status: fail");
			$finish;
		end
	end

	// Offers one word and returns at the edge where it is accepted. Valid stays
	// high so the next word can follow without a bubble.
	task automatic send_word(input req_type_t kind, input logic [2:0] fn,
		input logic [7:0] off, input logic [7:0] data);
		req_ch.valid           <= 1'b1;
		req_ch.req_type        <= kind;
		req_ch.function_number <= fn;
		req_ch.reg_offset      <= off;
		req_ch.write_byte      <= data;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		words_sent++;
	endtask

	task automatic cfg_read(input logic [7:0] off, input logic [2:0] fn);
		send_word(REQ_READ, fn, off, 8'($urandom_range(0, 255)));
	endtask

	task automatic cfg_write(input logic [7:0] off, input logic [7:0] data,
		input logic [2:0] fn);
		send_word(REQ_WRITE, fn, off, data);
	endtask

	initial begin
		int burst;
		int gap;
		int n;
		logic [7:0] off;
		logic [7:0] last_off;
		logic [2:0] fn;
		arst_n                 <= 1'b0;
		req_ch.valid           <= 1'b0;
		req_ch.req_type        <= REQ_READ;
		req_ch.function_number <= FN_MAIN;
		req_ch.reg_offset      <= 8'h00;
		req_ch.write_byte      <= 8'h00;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset image, absent function and the read-only identity bytes.
		cfg_read(8'h00, FN_MAIN);
		cfg_read(8'hff, FN_MAIN);
		cfg_read(8'h4c, FN_MAIN);
		cfg_read(8'h00, FN_LAST);
		cfg_write(8'h00, 8'hff, FN_MAIN);
		cfg_read(8'h00, FN_MAIN);
		cfg_write(8'h0b, 8'hff, FN_MAIN);
		cfg_write(8'h0e, 8'h55, FN_MAIN);
		cfg_write(8'h4b, 8'haa, FN_MAIN);
		cfg_read(8'h4b, FN_MAIN);
		cfg_write(8'h4c, 8'hff, FN_MAIN);
		cfg_read(8'h4c, FN_MAIN);
		// Command byte masking and the fixed status bytes.
		cfg_write(OFF_COMMAND, 8'hff, FN_MAIN);
		cfg_read(OFF_COMMAND, FN_MAIN);
		cfg_write(OFF_COMMAND, 8'h00, FN_MAIN);
		cfg_read(OFF_COMMAND, FN_MAIN);
		cfg_write(OFF_STATUS_LO, 8'hff, FN_MAIN);
		cfg_write(OFF_STATUS_HI, 8'hff, FN_MAIN);
		cfg_write(OFF_STATUS_FIX, 8'hfd, FN_MAIN);
		cfg_read(OFF_STATUS_FIX, FN_MAIN);
		// A write to a missing function must not land in the store.
		cfg_write(8'hff, 8'hff, FN_LAST);
		cfg_read(8'hff, FN_MAIN);
		// Routing bytes, disabled and enabled, on every pin.
		cfg_write(OFF_ROUTE_LO, 8'h8f, FN_MAIN);
		cfg_write(8'h61, 8'h0f, FN_MAIN);
		cfg_write(8'h62, 8'h7a, FN_MAIN);
		cfg_write(OFF_ROUTE_HI, 8'h00, FN_MAIN);
		cfg_read(8'h61, FN_MAIN);

		last_off = 8'h00;
		n = 0;
		while (n < RANDOM_WORDS) begin
			burst = $urandom_range(1, 40);
			for (int k = 0; k < burst && n < RANDOM_WORDS; k++) begin
				// Revisit the last offset often so writes get read back.
				if ($urandom_range(0, 2) == 0) begin
					off = last_off;
				end else begin
					case ($urandom_range(0, 3))
						0:       off = OFF_ROUTE_LO + 8'($urandom_range(0, 3));
						1:       off = 8'($urandom_range(0, 16));
						2:       off = 8'($urandom_range(8'h40, 8'h50));
						default: off = 8'($urandom_range(0, 255));
					endcase
				end
				fn = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(1, 7)) : FN_MAIN;
				send_word(req_type_t'($urandom_range(0, 1)), fn, off,
					8'($urandom_range(0, 255)));
				last_off = off;
				n++;
			end
			if ($urandom_range(0, 3) != 0) begin
				gap = $urandom_range(1, 12);
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end

		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d request words and checked %0d response words, %0d routing updates.",
			words_sent, replies_seen, routes_seen);
		$display("Covered read-only, masked and fixed bytes, absent functions and a %0d-cycle stall.",
			HOLD_CYCLES);
		if (fail_count == 0 && pending == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d mismatches, %0d words never answered", fail_count, pending);
			$display("status: fail");
		end
		$finish;
	end

	// Response side: ready follows a pattern that changes every so often, with
	// one long hold-off so the block backs up onto its request channel.
	initial begin
		rx_mode_t mode;
		int mode_left;
		int hold_left;
		int phase;
		bit held;
		mode      = RX_ALWAYS;
		mode_left = 0;
		hold_left = 0;
		phase     = 0;
		held      = 1'b0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!held && words_sent >= HOLD_AT) begin
				held      = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode      = rx_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(16, 160);
				end
				mode_left--;
				phase++;
				case (mode)
					RX_ALWAYS:      rsp_ch.ready <= 1'b1;
					RX_COIN:        rsp_ch.ready <= 1'($urandom_range(0, 1));
					RX_ONE_IN_FOUR: rsp_ch.ready <= (phase % 4 == 0);
					default:        rsp_ch.ready <= ($urandom_range(0, 6) != 0);
				endcase
			end
		end
	end

endmodule

>>> filelist.f
+incdir+sv
sv/pib_pkg.sv
sv/pib_if.sv
sv/pci_isa_bridge_config_space.sv
sv/pib_checker.sv
test/pib_cfg_checker.sv
test/tb_pci_isa_bridge_config_space.sv
